>>> rtl/core/analog_stick_radial_deadzone_defines.svh
// Assertion macros for the analog stick radial deadzone conditioner.
// Used by the top level only; it depends on nothing else.
`ifndef ANALOG_STICK_RADIAL_DEADZONE_DEFINES_SVH
`define ANALOG_STICK_RADIAL_DEADZONE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASRD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay in clock cycles.
`define ASRD_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> rtl/core/asrd_pkg.sv
// Package for the analog stick radial deadzone conditioner.
// Holds the request and result types, register codes and fixed widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package asrd_pkg;

    localparam int RAW_BITS   = 8;
    localparam int FRAC       = 14;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam int unsigned ONE_Q14   = 16384;
    localparam int unsigned HALF_Q14  = 8192;
    localparam int unsigned RANGE_MIN = 128;
    localparam int unsigned RANGE_MAX = 384;
    localparam int unsigned RANGE_RST = 256;
    localparam int unsigned RANGE_DIV = 100;
    localparam int unsigned DZ_MAX    = 256;
    localparam int unsigned CLIP_LIM  = ONE_Q14 * ONE_Q14;

    // Axis scaling: round(|raw| * 2^22 / (100 * range)).
    localparam int AX_W      = RAW_BITS + 8;
    localparam int DEN_A_W   = 16;
    localparam int DA_DEN_W  = DEN_A_W + 1;
    localparam int DA_SHIFT  = 23;
    localparam int DA_NUM_W  = RAW_BITS + DA_SHIFT + 1;

    // Square roots (shared step width for both radius computations).
    localparam int SQ_N      = AX_W + 1;
    localparam int SUM1_W    = 2 * AX_W + 1;

    // Unit-circle clip.
    localparam int B_W       = FRAC + 1;
    localparam int CL_DEN_W  = SQ_N + 1;
    localparam int CL_NUM_W  = AX_W + FRAC + 2;

    // Deadzone rescale.
    localparam int SQ2_W     = B_W + 1;
    localparam int D_W       = FRAC + 1;
    localparam int DZ_SHIFT  = FRAC - 8;
    localparam int P_W       = B_W + SQ2_W;
    localparam int Q_W       = SQ2_W + D_W;
    localparam int FD_DEN_W  = Q_W + 1;
    localparam int FN_W      = P_W + FRAC + 2;
    localparam int FQ        = SQ2_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT_X = 3'd0,
        CFG_INVERT_Y = 3'd1,
        CFG_DEADZONE = 3'd2,
        CFG_RANGE    = 3'd3
    } cfg_reg_t;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef struct packed {
        logic                       pad_connected;
        logic signed [RAW_BITS-1:0] raw_x;
        logic signed [RAW_BITS-1:0] raw_y;
        logic [1:0]                 direction;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] stick_x;
        logic signed [OUT_W-1:0] stick_y;
        logic                    direction_active;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/analog_stick_radial_deadzone.sv
// Top level of the analog stick radial deadzone conditioner: one deep pipeline.
// Depends on asrd_pkg and analog_stick_radial_deadzone_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken on every clock edge at which start is high; busy is always low, so a
// new stick sample may enter in every cycle and the sustained rate is one sample per clock.
// Each result appears on result for exactly one cycle, marked by done, and results leave in
// request order. The receiver cannot stall the block and none is needed, since nothing
// waits on a later stage. The depth of the pipeline is set by the chain of bit-per-stage
// units: the axis scaling divider (16 stages), two square roots (17 stages each), the
// circle clip divider (15 stages) and the deadzone divider (16 stages), plus the multiply
// and sum stages between them. Configuration registers are written through the
// cfg_valid/cfg_ready channel, which is always ready; write them only while no request is
// in flight.

`include "analog_stick_radial_deadzone_defines.svh"

module analog_stick_radial_deadzone (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire asrd_pkg::sample_t            sample,
    output logic                              done,
    output asrd_pkg::result_t                 result,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [asrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [asrd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import asrd_pkg::*;

    // Stage numbering along the pipeline.
    localparam int S_SQ1   = AX_W + 1;          // axis squares
    localparam int S_SUM1  = S_SQ1 + 1;         // sum of squares, first root starts
    localparam int S_CL    = S_SUM1 + SQ_N + 1; // clip divider starts
    localparam int S_BQ    = S_CL + B_W + 1;    // clipped axes and their squares
    localparam int S_SUM2  = S_BQ + 1;          // second root starts
    localparam int S_M1    = S_SUM2 + SQ_N + 1; // deadzone products
    localparam int S_FD    = S_M1 + 1;          // deadzone divider starts
    localparam int S_FQ    = S_FD + FQ;         // deadzone quotient ready
    localparam int S_OUT   = S_FQ + 1;          // output register
    localparam int LATENCY = S_OUT + 1;

    // Side information that travels with each request.
    typedef struct packed {
        logic            pad;
        logic            nx;
        logic            ny;
        logic [1:0]      dir;
        logic [AX_W-1:0] ax;
        logic [AX_W-1:0] ay;
        logic            clip;
        logic [B_W-1:0]  bx;
        logic [B_W-1:0]  by;
        logic            zero;
    } car_t;

    // One restoring division step for the axis scaling.
    function automatic logic [DA_DEN_W+AX_W-1:0] da_step(
        input logic [DA_DEN_W-1:0] rem,
        input logic [AX_W-1:0]     nq,
        input logic [DA_DEN_W-1:0] den
    );
        logic [DA_DEN_W:0] t;
        logic [DA_DEN_W:0] d;
        logic [DA_DEN_W:0] diff;
        t    = {rem, nq[AX_W-1]};
        d    = {1'b0, den};
        diff = t - d;
        if (t >= d)
            return {diff[DA_DEN_W-1:0], nq[AX_W-2:0], 1'b1};
        else
            return {t[DA_DEN_W-1:0], nq[AX_W-2:0], 1'b0};
    endfunction

    // One restoring division step for the circle clip.
    function automatic logic [CL_DEN_W+B_W-1:0] cl_step(
        input logic [CL_DEN_W-1:0] rem,
        input logic [B_W-1:0]      nq,
        input logic [CL_DEN_W-1:0] den
    );
        logic [CL_DEN_W:0] t;
        logic [CL_DEN_W:0] d;
        logic [CL_DEN_W:0] diff;
        t    = {rem, nq[B_W-1]};
        d    = {1'b0, den};
        diff = t - d;
        if (t >= d)
            return {diff[CL_DEN_W-1:0], nq[B_W-2:0], 1'b1};
        else
            return {t[CL_DEN_W-1:0], nq[B_W-2:0], 1'b0};
    endfunction

    // One restoring division step for the deadzone rescale.
    function automatic logic [FD_DEN_W+FQ-1:0] fd_step(
        input logic [FD_DEN_W-1:0] rem,
        input logic [FQ-1:0]       nq,
        input logic [FD_DEN_W-1:0] den
    );
        logic [FD_DEN_W:0] t;
        logic [FD_DEN_W:0] d;
        logic [FD_DEN_W:0] diff;
        t    = {rem, nq[FQ-1]};
        d    = {1'b0, den};
        diff = t - d;
        if (t >= d)
            return {diff[FD_DEN_W-1:0], nq[FQ-2:0], 1'b1};
        else
            return {t[FD_DEN_W-1:0], nq[FQ-2:0], 1'b0};
    endfunction

    // One digit of an integer square root: returns {remainder, root, remaining radicand}.
    function automatic logic [4*SQ_N+1:0] sq_step(
        input logic [SQ_N+1:0]   rem,
        input logic [SQ_N-1:0]   root,
        input logic [2*SQ_N-1:0] v
    );
        logic [SQ_N+3:0] t;
        logic [SQ_N+3:0] trial;
        logic [SQ_N+3:0] diff;
        t     = {rem, v[2*SQ_N-1 -: 2]};
        trial = {2'b00, root, 2'b01};
        diff  = t - trial;
        if (t >= trial)
            return {diff[SQ_N+1:0], root[SQ_N-2:0], 1'b1, v[2*SQ_N-3:0], 2'b00};
        else
            return {t[SQ_N+1:0], root[SQ_N-2:0], 1'b0, v[2*SQ_N-3:0], 2'b00};
    endfunction

    // Configuration registers.
    logic                  invert_x_reg;
    logic                  invert_y_reg;
    logic [CFG_DATA_W-1:0] deadzone_reg;
    logic [CFG_DATA_W-1:0] range_reg;

    // Valid bits and side information.
    logic [S_OUT:0] vld_reg;
    car_t           car_reg [0:S_FQ];

    // Axis scaling divider.
    logic [DA_DEN_W-1:0] da_rem_x_reg [0:AX_W];
    logic [DA_DEN_W-1:0] da_rem_y_reg [0:AX_W];
    logic [AX_W-1:0]     da_nq_x_reg  [0:AX_W];
    logic [AX_W-1:0]     da_nq_y_reg  [0:AX_W];
    logic [DA_DEN_W-1:0] da_den_reg   [0:AX_W];

    // First radius.
    logic [2*AX_W-1:0] sqx_reg;
    logic [2*AX_W-1:0] sqy_reg;
    logic [SQ_N+1:0]   sq1_rem_reg  [0:SQ_N];
    logic [SQ_N-1:0]   sq1_root_reg [0:SQ_N];
    logic [2*SQ_N-1:0] sq1_v_reg    [0:SQ_N];

    // Clip divider.
    logic [CL_DEN_W-1:0] cl_rem_x_reg [0:B_W];
    logic [CL_DEN_W-1:0] cl_rem_y_reg [0:B_W];
    logic [B_W-1:0]      cl_nq_x_reg  [0:B_W];
    logic [B_W-1:0]      cl_nq_y_reg  [0:B_W];
    logic [CL_DEN_W-1:0] cl_den_reg   [0:B_W];

    // Second radius.
    logic [2*B_W-1:0]  sqbx_reg;
    logic [2*B_W-1:0]  sqby_reg;
    logic [SQ_N+1:0]   sq2_rem_reg  [0:SQ_N];
    logic [SQ_N-1:0]   sq2_root_reg [0:SQ_N];
    logic [2*SQ_N-1:0] sq2_v_reg    [0:SQ_N];

    // Deadzone rescale.
    logic [P_W-1:0]      px_reg;
    logic [P_W-1:0]      py_reg;
    logic [Q_W-1:0]      q_reg;
    logic [FD_DEN_W-1:0] fd_rem_x_reg [0:FQ];
    logic [FD_DEN_W-1:0] fd_rem_y_reg [0:FQ];
    logic [FQ-1:0]       fd_nq_x_reg  [0:FQ];
    logic [FQ-1:0]       fd_nq_y_reg  [0:FQ];
    logic [FD_DEN_W-1:0] fd_den_reg   [0:FQ];

    result_t result_reg;

    // Combinational signals between stages.
    logic                  accept;
    car_t                  car_next [0:S_FQ];
    logic [CFG_DATA_W-1:0] rng_c;
    logic [DEN_A_W-1:0]    den_a;
    logic [RAW_BITS-1:0]   mag_x;
    logic [RAW_BITS-1:0]   mag_y;
    logic [DA_NUM_W-1:0]   num_ax;
    logic [DA_NUM_W-1:0]   num_ay;
    logic [SUM1_W-1:0]     sum1;
    logic [SQ_N-1:0]       r1;
    logic [CL_NUM_W-1:0]   num_cx;
    logic [CL_NUM_W-1:0]   num_cy;
    logic [B_W-1:0]        bx;
    logic [B_W-1:0]        by;
    logic [SQ2_W-1:0]      r2;
    logic [CFG_DATA_W-1:0] dz_c;
    logic [D_W-1:0]        dz_d;
    logic [SQ2_W-1:0]      r2_less;
    logic [FN_W-1:0]       num_fx;
    logic [FN_W-1:0]       num_fy;
    logic [OUT_W-1:0]      mag_ox;
    logic [OUT_W-1:0]      mag_oy;
    logic                  act;
    result_t               result_next;

    // The datapath has no stall, so a request is taken whenever start is high.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    // Register file: writes to indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_x_reg <= 1'b0;
            invert_y_reg <= 1'b0;
            deadzone_reg <= '0;
            range_reg    <= CFG_DATA_W'(RANGE_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INVERT_X: invert_x_reg <= cfg_data[0];
                CFG_INVERT_Y: invert_y_reg <= cfg_data[0];
                CFG_DEADZONE: deadzone_reg <= cfg_data;
                CFG_RANGE:    range_reg    <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[S_OUT-1:0], accept};
    end

    // Input stage: clamp the range, take the axes apart into sign and magnitude and set up
    // the rounded division |raw| * 2^23 + den over 2 * den.
    always_comb
    begin
        if (range_reg < CFG_DATA_W'(RANGE_MIN))
            rng_c = CFG_DATA_W'(RANGE_MIN);
        else if (range_reg > CFG_DATA_W'(RANGE_MAX))
            rng_c = CFG_DATA_W'(RANGE_MAX);
        else
            rng_c = range_reg;
        den_a  = DEN_A_W'(rng_c) * DEN_A_W'(RANGE_DIV);
        mag_x  = sample.raw_x[RAW_BITS-1] ? (~sample.raw_x + 1'b1) : sample.raw_x;
        mag_y  = sample.raw_y[RAW_BITS-1] ? (~sample.raw_y + 1'b1) : sample.raw_y;
        num_ax = DA_NUM_W'({mag_x, {DA_SHIFT{1'b0}}}) + DA_NUM_W'(den_a);
        num_ay = DA_NUM_W'({mag_y, {DA_SHIFT{1'b0}}}) + DA_NUM_W'(den_a);
    end

    // Side information: copied down the line, with fields filled in where they arise.
    always_comb
    begin
        car_next[0]     = '0;
        car_next[0].pad = sample.pad_connected;
        car_next[0].nx  = sample.raw_x[RAW_BITS-1] ^ invert_x_reg;
        car_next[0].ny  = sample.raw_y[RAW_BITS-1] ^ invert_y_reg;
        car_next[0].dir = sample.direction;
        for (int k = 1; k <= S_FQ; k++)
            car_next[k] = car_reg[k-1];
        car_next[S_SQ1].ax   = da_nq_x_reg[AX_W];
        car_next[S_SQ1].ay   = da_nq_y_reg[AX_W];
        car_next[S_SUM1].clip = sum1 > SUM1_W'(CLIP_LIM);
        car_next[S_BQ].bx    = bx;
        car_next[S_BQ].by    = by;
        car_next[S_M1].zero  = !((dz_d < D_W'(ONE_Q14)) && (r2 > SQ2_W'(dz_d)));
    end

    always_ff @(posedge clk)
    begin
        car_reg <= car_next;
    end

    // Axis scaling divider: one quotient bit per stage.
    always_ff @(posedge clk)
    begin
        da_rem_x_reg[0] <= DA_DEN_W'(num_ax >> AX_W);
        da_rem_y_reg[0] <= DA_DEN_W'(num_ay >> AX_W);
        da_nq_x_reg[0]  <= num_ax[AX_W-1:0];
        da_nq_y_reg[0]  <= num_ay[AX_W-1:0];
        da_den_reg[0]   <= {den_a, 1'b0};
        for (int k = 1; k <= AX_W; k++)
        begin
            {da_rem_x_reg[k], da_nq_x_reg[k]} <=
                da_step(da_rem_x_reg[k-1], da_nq_x_reg[k-1], da_den_reg[k-1]);
            {da_rem_y_reg[k], da_nq_y_reg[k]} <=
                da_step(da_rem_y_reg[k-1], da_nq_y_reg[k-1], da_den_reg[k-1]);
            da_den_reg[k] <= da_den_reg[k-1];
        end
    end

    // First radius: squares, their sum, then the digit-serial square root.
    assign sum1 = SUM1_W'(sqx_reg) + SUM1_W'(sqy_reg);

    always_ff @(posedge clk)
    begin
        sqx_reg <= da_nq_x_reg[AX_W] * da_nq_x_reg[AX_W];
        sqy_reg <= da_nq_y_reg[AX_W] * da_nq_y_reg[AX_W];
        sq1_rem_reg[0]  <= '0;
        sq1_root_reg[0] <= '0;
        sq1_v_reg[0]    <= (2*SQ_N)'(sum1);
        for (int k = 1; k <= SQ_N; k++)
            {sq1_rem_reg[k], sq1_root_reg[k], sq1_v_reg[k]} <=
                sq_step(sq1_rem_reg[k-1], sq1_root_reg[k-1], sq1_v_reg[k-1]);
    end

    // Clip divider: round(a * 2^14 / r), only used when the vector leaves the circle.
    always_comb
    begin
        r1     = sq1_root_reg[SQ_N];
        num_cx = (CL_NUM_W'(car_reg[S_CL-1].ax) << (FRAC + 1)) + CL_NUM_W'(r1);
        num_cy = (CL_NUM_W'(car_reg[S_CL-1].ay) << (FRAC + 1)) + CL_NUM_W'(r1);
    end

    always_ff @(posedge clk)
    begin
        cl_rem_x_reg[0] <= CL_DEN_W'(num_cx >> B_W);
        cl_rem_y_reg[0] <= CL_DEN_W'(num_cy >> B_W);
        cl_nq_x_reg[0]  <= num_cx[B_W-1:0];
        cl_nq_y_reg[0]  <= num_cy[B_W-1:0];
        cl_den_reg[0]   <= {r1, 1'b0};
        for (int k = 1; k <= B_W; k++)
        begin
            {cl_rem_x_reg[k], cl_nq_x_reg[k]} <=
                cl_step(cl_rem_x_reg[k-1], cl_nq_x_reg[k-1], cl_den_reg[k-1]);
            {cl_rem_y_reg[k], cl_nq_y_reg[k]} <=
                cl_step(cl_rem_y_reg[k-1], cl_nq_y_reg[k-1], cl_den_reg[k-1]);
            cl_den_reg[k] <= cl_den_reg[k-1];
        end
    end

    // Inside the circle the scaled axes are already at most 1.0 and pass unchanged.
    always_comb
    begin
        bx = car_reg[S_BQ-1].clip ? cl_nq_x_reg[B_W] : B_W'(car_reg[S_BQ-1].ax);
        by = car_reg[S_BQ-1].clip ? cl_nq_y_reg[B_W] : B_W'(car_reg[S_BQ-1].ay);
    end

    // Second radius over the clipped vector.
    always_ff @(posedge clk)
    begin
        sqbx_reg <= bx * bx;
        sqby_reg <= by * by;
        sq2_rem_reg[0]  <= '0;
        sq2_root_reg[0] <= '0;
        sq2_v_reg[0]    <= (2*SQ_N)'(sqbx_reg) + (2*SQ_N)'(sqby_reg);
        for (int k = 1; k <= SQ_N; k++)
            {sq2_rem_reg[k], sq2_root_reg[k], sq2_v_reg[k]} <=
                sq_step(sq2_rem_reg[k-1], sq2_root_reg[k-1], sq2_v_reg[k-1]);
    end

    // Deadzone: out = round(b * (r - D) * 2^14 / (r * (1.0 - D))).
    always_comb
    begin
        r2      = sq2_root_reg[SQ_N][SQ2_W-1:0];
        dz_c    = (deadzone_reg > CFG_DATA_W'(DZ_MAX)) ? CFG_DATA_W'(DZ_MAX) : deadzone_reg;
        dz_d    = D_W'(dz_c) << DZ_SHIFT;
        r2_less = r2 - SQ2_W'(dz_d);
        num_fx  = (FN_W'(px_reg) << (FRAC + 1)) + FN_W'(q_reg);
        num_fy  = (FN_W'(py_reg) << (FRAC + 1)) + FN_W'(q_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg <= P_W'(car_reg[S_M1-1].bx) * P_W'(r2_less);
        py_reg <= P_W'(car_reg[S_M1-1].by) * P_W'(r2_less);
        q_reg  <= Q_W'(r2) * Q_W'(D_W'(ONE_Q14) - dz_d);
        fd_rem_x_reg[0] <= FD_DEN_W'(num_fx >> FQ);
        fd_rem_y_reg[0] <= FD_DEN_W'(num_fy >> FQ);
        fd_nq_x_reg[0]  <= num_fx[FQ-1:0];
        fd_nq_y_reg[0]  <= num_fy[FQ-1:0];
        fd_den_reg[0]   <= {q_reg, 1'b0};
        for (int k = 1; k <= FQ; k++)
        begin
            {fd_rem_x_reg[k], fd_nq_x_reg[k]} <=
                fd_step(fd_rem_x_reg[k-1], fd_nq_x_reg[k-1], fd_den_reg[k-1]);
            {fd_rem_y_reg[k], fd_nq_y_reg[k]} <=
                fd_step(fd_rem_y_reg[k-1], fd_nq_y_reg[k-1], fd_den_reg[k-1]);
            fd_den_reg[k] <= fd_den_reg[k-1];
        end
    end

    // Output stage: saturate at 1.0, restore the signs, test the queried direction and
    // force a zero result for a disconnected pad or a vector inside the deadzone.
    always_comb
    begin
        if (car_reg[S_FQ].zero || !car_reg[S_FQ].pad)
        begin
            mag_ox = '0;
            mag_oy = '0;
        end
        else
        begin
            mag_ox = (fd_nq_x_reg[FQ] > OUT_W'(ONE_Q14)) ? OUT_W'(ONE_Q14) : fd_nq_x_reg[FQ];
            mag_oy = (fd_nq_y_reg[FQ] > OUT_W'(ONE_Q14)) ? OUT_W'(ONE_Q14) : fd_nq_y_reg[FQ];
        end
        unique case (car_reg[S_FQ].dir)
            DIR_RIGHT: act = !car_reg[S_FQ].nx && (mag_ox > OUT_W'(HALF_Q14));
            DIR_LEFT:  act =  car_reg[S_FQ].nx && (mag_ox > OUT_W'(HALF_Q14));
            DIR_UP:    act = !car_reg[S_FQ].ny && (mag_oy > OUT_W'(HALF_Q14));
            DIR_DOWN:  act =  car_reg[S_FQ].ny && (mag_oy > OUT_W'(HALF_Q14));
            default:   act = 1'b0;
        endcase
        result_next.stick_x          = car_reg[S_FQ].nx ? (~mag_ox + 1'b1) : mag_ox;
        result_next.stick_y          = car_reg[S_FQ].ny ? (~mag_oy + 1'b1) : mag_oy;
        result_next.direction_active = act;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = vld_reg[S_OUT];
    assign result = result_reg;

    // Every request comes out exactly once, after the fixed pipeline latency.
    `ASRD_ASSERT_DLY(a_fixed_latency, clk, rst_n, accept, LATENCY, done, "result missing at fixed latency")

    // Results always lie within the unit square of Q1.14.
    `ASRD_ASSERT_IMP(a_result_range, clk, rst_n, done, ($signed(result.stick_x) <= 16'sd16384) && ($signed(result.stick_x) >= -16'sd16384) && ($signed(result.stick_y) <= 16'sd16384) && ($signed(result.stick_y) >= -16'sd16384), "result out of range")

    // An active direction needs one axis past one half.
    `ASRD_ASSERT_IMP(a_active_half, clk, rst_n, done && result.direction_active, ($signed(result.stick_x) > 16'sd8192) || ($signed(result.stick_x) < -16'sd8192) || ($signed(result.stick_y) > 16'sd8192) || ($signed(result.stick_y) < -16'sd8192), "direction active below one half")

endmodule

`default_nettype wire
